FILE: sv/ose_pkg.sv
package ose_pkg;

  localparam int WORD_W = 16;
  localparam int CNT_W  = 8;

  typedef enum logic [2:0] {
    REQ_PUSH   = 3'd0,
    REQ_DROP   = 3'd1,
    REQ_POP    = 3'd2,
    REQ_PEEK   = 3'd3,
    REQ_SNIP   = 3'd4,
    REQ_RDINC  = 3'd5,
    REQ_ADJUST = 3'd6,
    REQ_CLEAR  = 3'd7
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OVER  = 2'd1,
    ST_UNDER = 2'd2
  } status_t;

  localparam logic CFG_NIL  = 1'b0;
  localparam logic CFG_ZERO = 1'b1;

endpackage

FILE: sv/operand_stack_engine.sv
// Channel   Handshake               Ports
// request   start & !busy           req_type, value, index, count, wanted
// result    done (one cycle)        data, counter_value, new_count, level,
//                                   high_water, status
// config    cfg_we                  cfg_index, cfg_wdata
//
// Push, drop, clear, trim or zero-length adjust and any flagged request: the result
// is registered for the cycle after the word is taken, and a new word can be taken in that same cycle.
// Pop, peek and read-increment pass through S_READ for the registered memory read.
// Snip: S_SNIP, then S_SHIFT moves the entries above down, one entry moved per cycle through the single write port.
// Adjust with padding: S_PAD writes wanted - count nil words, one nil word written per cycle.
// Reset has no clearing pass; the receiver cannot stall results.
module operand_stack_engine import ose_pkg::*; #(
  parameter int STACK_DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  req_type,
  input  logic [15:0] value,
  input  logic [7:0]  index,
  input  logic [7:0]  count,
  input  logic [7:0]  wanted,
  output logic        done,
  output logic [15:0] data,
  output logic [15:0] counter_value,
  output logic [7:0]  new_count,
  output logic [7:0]  level,
  output logic [7:0]  high_water,
  output logic [1:0]  status,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int LW = $clog2(STACK_DEPTH + 1);
  localparam int CW = (LW > 9) ? LW + 1 : 10;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_SNIP  = 5'b00100,
    S_SHIFT = 5'b01000,
    S_PAD   = 5'b10000
  } state_t;

  state_t            state, state_next;
  req_t              req, req_next;
  logic [LW-1:0]     top, top_next;
  logic [LW-1:0]     hw, hw_next;
  logic [LW-1:0]     ptr, ptr_next;
  logic [CNT_W-1:0]  rem, rem_next;
  logic [WORD_W-1:0] nil_word, zero_word;
  logic [WORD_W-1:0] data_next, ctr_next;
  logic [CNT_W-1:0]  ncount_next;
  status_t           stat, stat_next;
  logic              done_next;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [WORD_W-1:0] mem_wdata, mem_rdata;

  logic [CW-1:0] top_c, hw_c, idx_c, cnt_c, want_c, depth_c;
  logic [CW-1:0] pos_c, diff_c, top_inc_c, top_dec_c, top_sub_c, ptr1_c, ptr2_c;
  logic          trim;
  logic [31:0]   top_ext, hw_ext;

  assign top_c     = CW'(top);
  assign hw_c      = CW'(hw);
  assign idx_c     = CW'(index);
  assign cnt_c     = CW'(count);
  assign want_c    = CW'(wanted);
  assign depth_c   = CW'(STACK_DEPTH);
  assign pos_c     = top_c - idx_c - CW'(1);
  assign trim      = count > wanted;
  assign diff_c    = trim ? cnt_c - want_c : want_c - cnt_c;
  assign top_inc_c = top_c + CW'(1);
  assign top_dec_c = top_c - CW'(1);
  assign ptr1_c    = CW'(ptr) + CW'(1);
  assign ptr2_c    = CW'(ptr) + CW'(2);
  // Both a drop and a trim take this path; only one applies to a given request.
  assign top_sub_c = (req_t'(req_type) == REQ_DROP) ? top_c - cnt_c : top_c - diff_c;

  always_comb begin
    state_next  = state;
    req_next    = req;
    top_next    = top;
    hw_next     = hw;
    ptr_next    = ptr;
    rem_next    = rem;
    data_next   = data;
    ctr_next    = counter_value;
    ncount_next = new_count;
    stat_next   = stat;
    done_next   = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = top[AW-1:0];
    mem_wdata   = value;
    mem_raddr   = top_dec_c[AW-1:0];

    unique case (state)
      S_IDLE: begin
        if (start) begin
          req_next    = req_t'(req_type);
          data_next   = '0;
          ctr_next    = '0;
          ncount_next = '0;
          stat_next   = ST_OK;
          done_next   = 1'b1;
          unique case (req_t'(req_type))
            REQ_PUSH: begin
              if (top_c >= depth_c) begin
                stat_next = ST_OVER;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = top[AW-1:0];
                mem_wdata = value;
                top_next  = top_inc_c[LW-1:0];
                if (top_inc_c > hw_c) begin
                  hw_next = top_inc_c[LW-1:0];
                end
              end
            end
            REQ_DROP: begin
              if (cnt_c > top_c) begin
                stat_next = ST_UNDER;
              end else begin
                top_next = top_sub_c[LW-1:0];
              end
            end
            REQ_POP: begin
              if (top == '0) begin
                stat_next = ST_UNDER;
              end else begin
                mem_raddr  = top_dec_c[AW-1:0];
                ptr_next   = top_dec_c[LW-1:0];
                top_next   = top_dec_c[LW-1:0];
                state_next = S_READ;
                done_next  = 1'b0;
              end
            end
            REQ_PEEK, REQ_SNIP, REQ_RDINC: begin
              if (idx_c >= top_c) begin
                stat_next = ST_UNDER;
              end else begin
                mem_raddr  = pos_c[AW-1:0];
                ptr_next   = pos_c[LW-1:0];
                state_next = (req_t'(req_type) == REQ_SNIP) ? S_SNIP : S_READ;
                done_next  = 1'b0;
              end
            end
            REQ_ADJUST: begin
              if (trim) begin
                if (diff_c > top_c) begin
                  stat_next   = ST_UNDER;
                  ncount_next = count;
                end else begin
                  top_next    = top_sub_c[LW-1:0];
                  ncount_next = wanted;
                end
              end else if (diff_c > depth_c - top_c) begin
                stat_next   = ST_OVER;
                ncount_next = count;
              end else begin
                ncount_next = wanted;
                if (diff_c != '0) begin
                  rem_next   = diff_c[CNT_W-1:0];
                  state_next = S_PAD;
                  done_next  = 1'b0;
                end
              end
            end
            REQ_CLEAR: begin
              top_next = '0;
            end
            default: begin
              top_next = top;
            end
          endcase
        end
      end

      S_READ: begin
        data_next = mem_rdata;
        if (req == REQ_RDINC) begin
          mem_we    = 1'b1;
          mem_waddr = ptr[AW-1:0];
          mem_wdata = mem_rdata + 16'd1;
          ctr_next  = mem_rdata - zero_word;
        end
        done_next  = 1'b1;
        state_next = S_IDLE;
      end

      S_SNIP: begin
        data_next = mem_rdata;
        if (ptr1_c == top_c) begin
          top_next   = top_dec_c[LW-1:0];
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          mem_raddr  = ptr1_c[AW-1:0];
          state_next = S_SHIFT;
        end
      end

      S_SHIFT: begin
        // Entry ptr+1 arrives now and moves down one place; ptr+2 is read ahead.
        mem_we    = 1'b1;
        mem_waddr = ptr[AW-1:0];
        mem_wdata = mem_rdata;
        ptr_next  = ptr1_c[LW-1:0];
        if (ptr2_c == top_c) begin
          top_next   = top_dec_c[LW-1:0];
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          mem_raddr = ptr2_c[AW-1:0];
        end
      end

      S_PAD: begin
        mem_we    = 1'b1;
        mem_waddr = top[AW-1:0];
        mem_wdata = nil_word;
        top_next  = top_inc_c[LW-1:0];
        if (top_inc_c > hw_c) begin
          hw_next = top_inc_c[LW-1:0];
        end
        rem_next = rem - 8'd1;
        if (rem == 8'd1) begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      top       <= '0;
      hw        <= '0;
      done      <= 1'b0;
      nil_word  <= '0;
      zero_word <= '0;
    end else begin
      state <= state_next;
      top   <= top_next;
      hw    <= hw_next;
      done  <= done_next;
      if (cfg_we) begin
        case (cfg_index)
          CFG_NIL:  nil_word  <= cfg_wdata;
          CFG_ZERO: zero_word <= cfg_wdata;
          default:  nil_word  <= nil_word;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    req           <= req_next;
    ptr           <= ptr_next;
    rem           <= rem_next;
    data          <= data_next;
    counter_value <= ctr_next;
    new_count     <= ncount_next;
    stat          <= stat_next;
  end

  ose_ram #(
    .WIDTH(WORD_W),
    .DEPTH(STACK_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign busy       = (state != S_IDLE);
  assign top_ext    = 32'(top);
  assign hw_ext     = 32'(hw);
  assign level      = top_ext[7:0];
  assign high_water = hw_ext[7:0];
  assign status     = stat;

endmodule

FILE: sv/ose_ram.sv
module ose_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/ose_checker.sv
module ose_checker import ose_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [7:0] level,
  input logic [7:0] high_water
);

  // A result only appears once its request has finished and the engine is free.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while engine busy");

  // Every result traces back to an accepted word or to work in progress.
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(start && !busy) || $past(busy)))
    else $error("result without a request");

  // With nothing taken and nothing in flight, depth and mark must hold.
  a_quiet: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$past(start) && !$past(busy)) |-> ($stable(level) && $stable(high_water)))
    else $error("stack depth moved while idle");

  a_reset: assert property (@(posedge clk)
    $past(rst) |-> (level == 8'd0 && high_water == 8'd0 && !busy && !done))
    else $error("bad state after reset");

endmodule

bind operand_stack_engine ose_checker u_ose_checker (.*);
